/* rtl/stt_pkg.sv */
// Shared types and constants for the software timer table unit.
// No dependencies; used by stt_datapath, stt_ctrl, the top level and the testbench.
package stt_pkg;

    localparam int SLOTS   = 16;
    localparam int IDX_W   = $clog2(SLOTS);
    localparam int CNT_W   = $clog2(SLOTS + 1);
    localparam int TASK_W  = 8;
    localparam int EVENT_W = 16;
    localparam int IVL_W   = 32;
    localparam int ENTRY_W = TASK_W + EVENT_W + 1 + IVL_W + IVL_W;

    typedef enum logic [1:0] {
        KIND_TICK     = 2'd0,
        KIND_ADD_ONCE = 2'd1,
        KIND_ADD_PER  = 2'd2,
        KIND_DELETE   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_SUCCESS   = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2
    } status_t;

    typedef struct packed {
        logic [TASK_W-1:0]  task_id;
        logic [EVENT_W-1:0] event_id;
        logic               periodic;
        logic [IVL_W-1:0]   interval;
        logic [IVL_W-1:0]   elapsed;
    } entry_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic             load_req;   // capture request fields
        logic             clr_rd;     // rd := 0, wr := 0
        logic             step;       // examine entry rd
        logic             tick_mode;  // step performs tick processing
        logic             append;     // write new entry at count
        logic             del_shift;  // delete compaction step
        logic             finish_tick;// count := wr
        logic             finish_del; // count := count - 1
        logic             emit;       // load output register
        logic             emit_exp;   // emitted result is an expiry notice
        logic [1:0]       emit_status;
        logic             emit_last;
    } stt_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic rd_done;    // rd has reached count
        logic match;      // entry rd matches the key
        logic expire;     // entry rd expires on this tick
        logic full;       // count == SLOTS
        logic out_busy;   // output register holds a result not taken this cycle
        logic more_exp;   // an expiry is pending to be emitted
    } stt_stat_t;

endpackage

/* rtl/stt_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module stt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;
endmodule

/* rtl/stt_datapath.sv */
// Datapath of the timer table: entry RAM, walk pointers, count and result register.
// Depends on stt_pkg and stt_ram.
module stt_datapath
    import stt_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  stt_cmd_t            cmd,
    output stt_stat_t           stat,
    input  logic [1:0]          s_kind,
    input  logic [TASK_W-1:0]   s_task,
    input  logic [EVENT_W-1:0]  s_event,
    input  logic [IVL_W-1:0]    s_interval,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_user,
    output logic [31:0]         m_data,
    output logic                m_last
);
    logic [TASK_W-1:0]  task_reg;
    logic [EVENT_W-1:0] event_reg;
    logic [IVL_W-1:0]   ivl_reg;
    logic               per_reg;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   rd_reg, wr_reg;
    logic               out_valid_reg;
    logic               out_user_reg;
    logic [31:0]        out_data_reg;
    logic               out_last_reg;
    logic               exp_pend_reg;
    logic [TASK_W-1:0]  exp_task_reg;
    logic [EVENT_W-1:0] exp_event_reg;

    entry_t             rd_entry;
    entry_t             wdata;
    logic [ENTRY_W-1:0] rdata_raw;
    logic               we;
    logic [IDX_W-1:0]   waddr;
    logic [IDX_W-1:0]   raddr;
    logic [IVL_W-1:0]   elapsed_inc;
    logic               expire;
    logic               match;

    // Read address runs one ahead: the controller steps entry rd while rd+1 is fetched.
    always_comb begin
        raddr = rd_reg[IDX_W-1:0];
        if (cmd.step || cmd.clr_rd) begin
            raddr = cmd.clr_rd ? '0 : IDX_W'(rd_reg + 1'b1);
        end
    end

    stt_ram #(.WIDTH(ENTRY_W), .DEPTH(SLOTS)) u_ram (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata_raw)
    );

    assign rd_entry    = entry_t'(rdata_raw);
    assign elapsed_inc = rd_entry.elapsed + 1'b1;
    assign expire      = (elapsed_inc >= rd_entry.interval);
    assign match       = (rd_entry.task_id == task_reg) && (rd_entry.event_id == event_reg);

    always_comb begin
        we    = 1'b0;
        waddr = wr_reg[IDX_W-1:0];
        wdata = rd_entry;
        if (cmd.append) begin
            we    = 1'b1;
            waddr = count_reg[IDX_W-1:0];
            wdata = '{task_id: task_reg, event_id: event_reg, periodic: per_reg,
                      interval: ivl_reg, elapsed: '0};
        end else if (cmd.step && cmd.tick_mode) begin
            we            = !expire || rd_entry.periodic;
            wdata.elapsed = expire ? '0 : elapsed_inc;
        end else if (cmd.del_shift) begin
            // Entry rd moves down to rd-1 (wr tracks rd-1 during compaction).
            we = 1'b1;
        end
    end

    always_comb begin
        count_next = count_reg;
        if (cmd.append) begin
            count_next = count_reg + 1'b1;
        end else if (cmd.finish_tick) begin
            count_next = wr_reg;
        end else if (cmd.finish_del) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            exp_pend_reg  <= 1'b0;
            rd_reg        <= '0;
            wr_reg        <= '0;
        end else begin
            count_reg <= count_next;
            if (cmd.clr_rd) begin
                rd_reg <= '0;
                wr_reg <= '0;
            end else if (cmd.step) begin
                rd_reg <= rd_reg + 1'b1;
                if (cmd.tick_mode) begin
                    if (we) begin
                        wr_reg <= wr_reg + 1'b1;
                    end
                end else if (!match) begin
                    wr_reg <= rd_reg + 1'b1;
                end
            end else if (cmd.del_shift) begin
                rd_reg <= rd_reg + 1'b1;
                wr_reg <= wr_reg + 1'b1;
            end
            if (cmd.step && cmd.tick_mode && expire) begin
                exp_pend_reg <= 1'b1;
            end else if (cmd.emit && cmd.emit_exp) begin
                exp_pend_reg <= 1'b0;
            end
            if (cmd.emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_req) begin
            task_reg  <= s_task;
            event_reg <= s_event;
            ivl_reg   <= s_interval;
            per_reg   <= (kind_t'(s_kind) == KIND_ADD_PER);
        end
        if (cmd.step && cmd.tick_mode && expire) begin
            exp_task_reg  <= rd_entry.task_id;
            exp_event_reg <= rd_entry.event_id;
        end
        if (cmd.emit) begin
            out_last_reg <= cmd.emit_last;
            out_user_reg <= cmd.emit_exp;
            if (cmd.emit_exp) begin
                out_data_reg <= {6'd0, exp_event_reg, exp_task_reg, 2'd0};
            end else begin
                out_data_reg <= {6'd0, 16'd0, 8'd0, cmd.emit_status};
            end
        end
    end

    assign stat.rd_done  = (rd_reg >= count_reg);
    assign stat.match    = match;
    assign stat.expire   = expire;
    assign stat.full     = (count_reg == CNT_W'(SLOTS));
    assign stat.out_busy = out_valid_reg && !m_ready;
    assign stat.more_exp = exp_pend_reg;

    assign m_valid = out_valid_reg;
    assign m_user  = out_user_reg;
    assign m_data  = out_data_reg;
    assign m_last  = out_last_reg;
endmodule

/* rtl/stt_ctrl.sv */
// Controller state machine of the timer table: sequences searches, ticks and replies.
// Depends on stt_pkg.
module stt_ctrl
    import stt_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_kind,
    input  stt_stat_t  stat,
    output stt_cmd_t   cmd
);
    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_PRIME = 7'b0000010,
        S_TICK  = 7'b0000100,
        S_SRCH  = 7'b0001000,
        S_SHIFT = 7'b0010000,
        S_DRAIN = 7'b0100000,
        S_REPLY = 7'b1000000
    } state_t;

    state_t      state_reg, state_next;
    kind_t       kind_reg;
    logic        found_reg, found_next;
    logic [1:0]  reply_reg, reply_next;

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        found_next = found_reg;
        reply_next = reply_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load_req = 1'b1;
                    cmd.clr_rd   = 1'b1;
                    found_next   = 1'b0;
                    state_next   = S_PRIME;
                end
            end
            S_PRIME: begin
                state_next = (kind_reg == KIND_TICK) ? S_TICK : S_SRCH;
            end
            S_TICK: begin
                // A held expiry goes out only once a later one is found or the walk ends,
                // so that the final notice of the tick can carry last.
                if (!stat.rd_done) begin
                    if (stat.expire && stat.more_exp) begin
                        if (!stat.out_busy) begin
                            cmd.emit      = 1'b1;
                            cmd.emit_exp  = 1'b1;
                            cmd.step      = 1'b1;
                            cmd.tick_mode = 1'b1;
                        end
                    end else begin
                        cmd.step      = 1'b1;
                        cmd.tick_mode = 1'b1;
                    end
                end else if (stat.more_exp) begin
                    if (!stat.out_busy) begin
                        cmd.emit        = 1'b1;
                        cmd.emit_exp    = 1'b1;
                        cmd.emit_last   = 1'b1;
                        cmd.finish_tick = 1'b1;
                        state_next      = S_IDLE;
                    end
                end else begin
                    cmd.finish_tick = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_SRCH: begin
                if (stat.rd_done) begin
                    if (kind_reg == KIND_DELETE) begin
                        reply_next = ST_NOT_FOUND;
                    end else if (stat.full) begin
                        reply_next = ST_FULL;
                    end else begin
                        reply_next  = ST_SUCCESS;
                        cmd.append  = 1'b1;
                    end
                    state_next = S_REPLY;
                end else if (stat.match) begin
                    reply_next = ST_SUCCESS;
                    if (kind_reg == KIND_DELETE) begin
                        cmd.step   = 1'b1;
                        state_next = S_SHIFT;
                    end else begin
                        state_next = S_REPLY;
                    end
                end else begin
                    cmd.step = 1'b1;
                end
            end
            S_SHIFT: begin
                if (stat.rd_done) begin
                    cmd.finish_del = 1'b1;
                    state_next     = S_REPLY;
                end else begin
                    cmd.del_shift = 1'b1;
                    cmd.step      = 1'b0;
                    state_next    = S_DRAIN;
                end
            end
            S_DRAIN: begin
                // Waits for the next entry's read to return.
                state_next = S_SHIFT;
            end
            S_REPLY: begin
                if (!stat.out_busy) begin
                    cmd.emit        = 1'b1;
                    cmd.emit_status = reply_reg;
                    cmd.emit_last   = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            found_reg <= 1'b0;
            reply_reg <= ST_SUCCESS;
            kind_reg  <= KIND_TICK;
        end else begin
            state_reg <= state_next;
            found_reg <= found_next;
            reply_reg <= reply_next;
            if (state_reg == S_IDLE && s_valid) begin
                kind_reg <= kind_t'(s_kind);
            end
        end
    end
endmodule

/* rtl/software_timer_table_unit.sv */
// Software timer table unit: one request at a time; a search walks one entry a cycle, a tick
// too unless the output stalls, and a delete moves each later entry down through the shift
// and drain states. An add replies after its search, a found delete after compaction, and a
// tick loads its last notice when its walk ends. A new request is taken only when idle.
// Reset: synchronous, active low; the table is empty after reset and no result is pending.
// Depends on stt_pkg, stt_ctrl and stt_datapath.
module software_timer_table_unit
    import stt_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // s_tuser: kind[1:0]
    input  logic [1:0]  s_tuser,
    // s_tdata: task_req[7:0], event_code[23:8], interval[55:24]
    input  logic [55:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // m_tuser: result_kind[0]
    output logic        m_tuser,
    // m_tdata: status[1:0], expired_task[9:2], expired_event[25:10], zeros above
    output logic [31:0] m_tdata,
    output logic        m_tlast
);
    stt_cmd_t  cmd;
    stt_stat_t stat;

    // The controller sequences and keeps the request kind and reply status; the table sits in the datapath.
    stt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_tvalid),
        .s_ready (s_tready),
        .s_kind  (s_tuser),
        .stat    (stat),
        .cmd     (cmd)
    );

    // Each request's fields are captured when it is accepted.
    stt_datapath u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .stat       (stat),
        .s_kind     (s_tuser),
        .s_task     (s_tdata[7:0]),
        .s_event    (s_tdata[23:8]),
        .s_interval (s_tdata[55:24]),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .m_user     (m_tuser),
        .m_data     (m_tdata),
        .m_last     (m_tlast)
    );
endmodule

/* rtl/stt_checker.sv */
// Port-level checks of the software timer table unit, bound to the top level.
// Depends on nothing but the top level's ports.
module stt_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic        m_tuser,
    input logic [31:0] m_tdata,
    input logic        m_tlast
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");
    a_reply_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tlast)
        else $error("status reply without last");
    a_reply_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[25:2] == 24'd0)
        else $error("status reply carries key");
    a_no_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while busy");
endmodule

bind software_timer_table_unit stt_checker u_stt_checker (.*);

/* sim/tb.sv */
// Testbench for the software timer table unit: random and directed requests, self-checking.
// Depends on stt_pkg and software_timer_table_unit; predicts every result in its own model.
`timescale 1ns / 1ps

module tb;
    import stt_pkg::*;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [1:0]  s_tuser;
    logic [55:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic        m_tuser;
    logic [31:0] m_tdata;
    logic        m_tlast;

    software_timer_table_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tuser(m_tuser), .m_tdata(m_tdata),
        .m_tlast(m_tlast)
    );

    // One expected result: the result kind, the packed tdata word and the tlast flag.
    typedef struct packed {
        logic        user;
        logic [31:0] data;
        logic        last;
    } timer_result_t;

    // Shadow copy of the timer table, kept packed in insertion order.
    logic [TASK_W-1:0]  tbl_task [SLOTS];
    logic [EVENT_W-1:0] tbl_event [SLOTS];
    logic               tbl_periodic [SLOTS];
    logic [IVL_W-1:0]   tbl_interval [SLOTS];
    logic [IVL_W-1:0]   tbl_elapsed [SLOTS];
    int                 tbl_count = 0;

    logic [63:0]   pending_requests [$];
    timer_result_t expected_results [$];

    int  send_idle_pct;
    int  recv_idle_pct;
    int  cycle_count = 0;
    int  fail_count = 0;

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    function automatic logic [31:0] pack_result(status_t st, logic [7:0] tk, logic [15:0] ev);
        logic [31:0] d;
        d = '0;
        d[1:0]   = st;
        d[9:2]   = tk;
        d[25:10] = ev;
        return d;
    endfunction

    function automatic int find_timer(logic [7:0] tk, logic [15:0] ev);
        for (int i = 0; i < tbl_count; i++)
            if (tbl_task[i] == tk && tbl_event[i] == ev)
                return i;
        return -1;
    endfunction

    // Applies one accepted request to the shadow table and queues the results it causes.
    task automatic predict_timer_request(logic [63:0] req);
        kind_t         k;
        logic [7:0]    tk;
        logic [15:0]   ev;
        logic [31:0]   ivl;
        int            idx;
        int            wr;
        int            n;
        bit            keep;
        timer_result_t r;
        k   = kind_t'(req[1:0]);
        tk  = req[9:2];
        ev  = req[25:10];
        ivl = req[57:26];
        r.last = 1'b1;
        r.user = 1'b0;
        if (k == KIND_TICK) begin
            wr = 0;
            n = 0;
            for (int rd = 0; rd < tbl_count; rd++) begin
                keep = 1'b1;
                tbl_elapsed[rd] = tbl_elapsed[rd] + 1;
                if (tbl_elapsed[rd] >= tbl_interval[rd]) begin
                    r.user = 1'b1;
                    r.data = pack_result(ST_SUCCESS, tbl_task[rd], tbl_event[rd]);
                    r.last = 1'b0;
                    expected_results.push_back(r);
                    n++;
                    if (tbl_periodic[rd])
                        tbl_elapsed[rd] = '0;
                    else
                        keep = 1'b0;
                end
                if (keep) begin
                    tbl_task[wr]     = tbl_task[rd];
                    tbl_event[wr]    = tbl_event[rd];
                    tbl_periodic[wr] = tbl_periodic[rd];
                    tbl_interval[wr] = tbl_interval[rd];
                    tbl_elapsed[wr]  = tbl_elapsed[rd];
                    wr++;
                end
            end
            tbl_count = wr;
            // Only the final expiry notice of a tick carries tlast.
            if (n > 0) begin
                r = expected_results.pop_back();
                r.last = 1'b1;
                expected_results.push_back(r);
            end
        end else if (k == KIND_DELETE) begin
            idx = find_timer(tk, ev);
            if (idx < 0) begin
                r.data = pack_result(ST_NOT_FOUND, '0, '0);
            end else begin
                for (int i = idx; i + 1 < tbl_count; i++) begin
                    tbl_task[i]     = tbl_task[i+1];
                    tbl_event[i]    = tbl_event[i+1];
                    tbl_periodic[i] = tbl_periodic[i+1];
                    tbl_interval[i] = tbl_interval[i+1];
                    tbl_elapsed[i]  = tbl_elapsed[i+1];
                end
                tbl_count--;
                r.data = pack_result(ST_SUCCESS, '0, '0);
            end
            expected_results.push_back(r);
        end else begin
            // An existing key is left untouched; otherwise append if there is room.
            if (find_timer(tk, ev) >= 0) begin
                r.data = pack_result(ST_SUCCESS, '0, '0);
            end else if (tbl_count >= SLOTS) begin
                r.data = pack_result(ST_FULL, '0, '0);
            end else begin
                tbl_task[tbl_count]     = tk;
                tbl_event[tbl_count]    = ev;
                tbl_periodic[tbl_count] = (k == KIND_ADD_PER);
                tbl_interval[tbl_count] = ivl;
                tbl_elapsed[tbl_count]  = '0;
                tbl_count++;
                r.data = pack_result(ST_SUCCESS, '0, '0);
            end
            expected_results.push_back(r);
        end
    endtask

    function automatic logic [63:0] make_request(kind_t k, logic [7:0] tk, logic [15:0] ev,
                                                 logic [31:0] ivl);
        logic [63:0] d;
        d = '0;
        d[1:0]   = k;
        d[9:2]   = tk;
        d[25:10] = ev;
        d[57:26] = ivl;
        return d;
    endfunction

    // Driver: presents the head of the pending queue, idling at random between requests.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tuser  <= '0;
            s_tdata  <= '0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_timer_request({6'd0, s_tdata, s_tuser});
                void'(pending_requests.pop_front());
            end
            if (!s_tvalid || s_tready) begin
                if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_tvalid <= 1'b1;
                    s_tuser  <= pending_requests[0][1:0];
                    s_tdata  <= pending_requests[0][57:2];
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each accepted result against the oldest expectation.
    always @(posedge aclk) begin
        timer_result_t exp_r;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result user=%b data=%h last=%b",
                             $time, m_tuser, m_tdata, m_tlast);
                    fail_count++;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (m_tuser !== exp_r.user || m_tdata[25:0] !== exp_r.data[25:0] ||
                        m_tlast !== exp_r.last) begin
                        $display("%0t: mismatch expected user=%b data=%h last=%b, %s",
                                 $time, exp_r.user, exp_r.data[25:0], exp_r.last, "actual");
                        $display("%0t:          actual user=%b data=%h last=%b",
                                 $time, m_tuser, m_tdata[25:0], m_tlast);
                        fail_count++;
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > 400000) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_requests.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(posedge aclk);
    endtask

    task automatic queue_random_request(int fill_bias);
        kind_t       k;
        logic [31:0] ivl;
        int          sel;
        // Keys come mostly from a small pool so that deletes and re-adds hit.
        sel = $urandom_range(99);
        if (sel < 35)
            k = KIND_TICK;
        else if (sel < 55 + fill_bias)
            k = KIND_ADD_ONCE;
        else if (sel < 75 + fill_bias)
            k = KIND_ADD_PER;
        else
            k = KIND_DELETE;
        ivl = ($urandom_range(9) == 0) ? $urandom : $urandom_range(6);
        if ($urandom_range(9) == 0)
            pending_requests.push_back(make_request(k, 8'($urandom), 16'($urandom), ivl));
        else
            pending_requests.push_back(make_request(k, 8'($urandom_range(23)),
                                                    16'(16'h00A0 + $urandom_range(1)), ivl));
    endtask

    initial begin
        aresetn       = 1'b0;
        send_idle_pct = 23;
        recv_idle_pct = 57;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: tick on an empty table, delete of an absent key, extreme fields.
        pending_requests.push_back(make_request(KIND_TICK, 8'hFF, 16'hFFFF, '1));
        pending_requests.push_back(make_request(KIND_DELETE, 8'h00, 16'h0000, '0));
        pending_requests.push_back(make_request(KIND_ADD_ONCE, 8'hFF, 16'hFFFF, 32'hFFFFFFFF));
        pending_requests.push_back(make_request(KIND_ADD_PER, 8'h00, 16'h0000, 32'd0));
        pending_requests.push_back(make_request(KIND_ADD_PER, 8'hFF, 16'hFFFF, 32'd3));
        pending_requests.push_back(make_request(KIND_ADD_ONCE, 8'h55, 16'hAAAA, 32'd1));
        pending_requests.push_back(make_request(KIND_ADD_ONCE, 8'hAA, 16'h5555, 32'd0));
        pending_requests.push_back(make_request(KIND_ADD_PER, 8'h12, 16'h3456, 32'd2));
        // Two one-shots expiring together in one walk.
        pending_requests.push_back(make_request(KIND_TICK, '0, '0, '0));
        pending_requests.push_back(make_request(KIND_TICK, '0, '0, '0));
        pending_requests.push_back(make_request(KIND_DELETE, 8'h12, 16'h3456, '0));
        pending_requests.push_back(make_request(KIND_DELETE, 8'h12, 16'h3456, '0));
        // Fill the table and overflow it.
        for (int i = 0; i < SLOTS + 2; i++)
            pending_requests.push_back(make_request(KIND_ADD_ONCE, 8'(8'h30 + i), 16'h0100,
                                                    32'd1));
        // All entries but the one with the largest interval expire on this tick.
        pending_requests.push_back(make_request(KIND_TICK, '0, '0, '0));
        wait_drained();

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 23 : (phase == 1) ? 57 : 0;
            recv_idle_pct = (phase == 0) ? 57 : (phase == 1) ? 23 : 0;
            for (int i = 0; i < 120; i++)
                queue_random_request(phase == 2 ? 10 : 0);
            wait_drained();
        end
        repeat (50) @(posedge aclk);
        if (fail_count == 0 && expected_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
